// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by fifo_with_delete_by_value_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on i_clk outside reset
`define AST_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

// next-cycle implication, checked on i_clk outside reset
`define AST_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/fwdbv_pkg.sv =====
`default_nettype none
package fwdbv_pkg;

    // default list capacity
    localparam int DEPTH_DEF = 16;

    // width of a stored value
    localparam int VALUE_W = 32;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DROPPED   = 2'd3
    } t_status;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                      cmp_en;
        logic                      ins_en;
        logic                      del_en;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/core/fwdbv_cell.sv =====
`default_nettype none
module fwdbv_cell (
    input  wire                                   i_clk,
    input  wire fwdbv_pkg::t_cell_ctrl            i_ctrl,
    input  wire                                   i_in_range,
    input  wire                                   i_tail,
    input  wire                                   i_found,
    input  wire signed [fwdbv_pkg::VALUE_W-1:0]   i_next_value,
    output logic                                  o_found,
    output logic signed [fwdbv_pkg::VALUE_W-1:0]  o_value
);

    logic signed [fwdbv_pkg::VALUE_W-1:0] r_value;
    logic                                 r_match;

    // first-match chain: this cell or one nearer the head matched
    assign o_found = i_found | r_match;
    assign o_value = r_value;

    // compare against the held entry, only while it is occupied
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= i_in_range && (r_value == i_ctrl.value);
        end
    end

    // append at the tail, or close the gap by taking the neighbour's entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && i_tail) begin
            r_value <= i_ctrl.value;
        end else if (i_ctrl.del_en && o_found) begin
            r_value <= i_next_value;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fifo_with_delete_by_value_core.sv =====
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------
// command   | start in, busy out        | i_opcode, i_value
// result    | o_valid out (one cycle)   | o_status, o_occupancy
//
// a transaction goes through accept, compare and apply; busy covers the compare
// and apply steps, so a new command is taken only after the last is applied.
// the compare runs in every cell at once; on a remove, the apply step resolves the first
// match through the cell chain and shifts later entries one place headward.
// i_rst_n is synchronous, active low, and clears the entry count and control;
// stored values are undefined until written. the result is not stallable.
`default_nettype none
`include "assert_macros.svh"
module fifo_with_delete_by_value_core #(
    parameter int DEPTH = fwdbv_pkg::DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire                                  i_opcode,
    input  wire signed [fwdbv_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic [4:0]                           o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state                               r_state, n_state;
    logic                                 r_op;
    logic signed [fwdbv_pkg::VALUE_W-1:0] r_value;
    logic [CW-1:0]                        r_count, n_count;
    logic                                 r_valid;
    fwdbv_pkg::t_status                   r_status, n_status;
    fwdbv_pkg::t_cell_ctrl                ctrl;
    logic [DEPTH:0]                       found_chain;
    logic signed [fwdbv_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic                                 full;
    logic                                 found;
    logic [OW-1:0]                        occ_ext;

    assign busy  = (r_state != S_IDLE);
    assign full  = (r_count == CW'(DEPTH));
    assign found = found_chain[DEPTH];

    // command capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_CMP;
            S_CMP:   n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // broadcast control to the cells
    always_comb begin
        ctrl.cmp_en = (r_state == S_CMP);
        ctrl.ins_en = (r_state == S_APPLY) && (r_op == fwdbv_pkg::OP_INSERT) && !full;
        ctrl.del_en = (r_state == S_APPLY) && (r_op == fwdbv_pkg::OP_REMOVE);
        ctrl.value  = r_value;
    end

    // the chain of cells
    assign found_chain[0] = 1'b0;
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [fwdbv_pkg::VALUE_W-1:0] next_value;
        if (gi == DEPTH - 1) begin : g_last
            assign next_value = cell_value[gi];
        end else begin : g_mid
            assign next_value = cell_value[gi + 1];
        end
        fwdbv_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_in_range   (CW'(gi) < r_count),
            .i_tail       (CW'(gi) == r_count),
            .i_found      (found_chain[gi]),
            .i_next_value (next_value),
            .o_found      (found_chain[gi + 1]),
            .o_value      (cell_value[gi])
        );
    end

    // count and status for the apply step
    always_comb begin
        n_count  = r_count;
        n_status = fwdbv_pkg::ST_INSERTED;
        if (r_op == fwdbv_pkg::OP_INSERT) begin
            if (full) begin
                n_status = fwdbv_pkg::ST_DROPPED;
            end else begin
                n_count  = r_count + CW'(1);
                n_status = fwdbv_pkg::ST_INSERTED;
            end
        end else begin
            if (found) begin
                n_count  = r_count - CW'(1);
                n_status = fwdbv_pkg::ST_REMOVED;
            end else begin
                n_status = fwdbv_pkg::ST_NOT_FOUND;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_APPLY);
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    // result status register
    always_ff @(posedge i_clk) begin
        if (r_state == S_APPLY) begin
            r_status <= n_status;
        end
    end

    // outputs
    assign occ_ext     = OW'(r_count);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_occupancy = occ_ext[4:0];

    // checks
    `AST_NXT(a_accept_to_cmp, start && !busy, r_state == S_CMP)
    `AST_IMP(a_result_idle, o_valid, r_state == S_IDLE && $past(r_state == S_APPLY))
    `AST_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `AST_IMP(a_drop_full, o_valid && o_status == fwdbv_pkg::ST_DROPPED, full)

endmodule
`default_nettype wire

// ===== tb/fifo_with_delete_by_value_core_tb.sv =====
`timescale 1ns / 1ps
module fifo_with_delete_by_value_core_tb;

    localparam int LIST_DEPTH  = fwdbv_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // expected outcome of one list operation
    typedef struct packed {
        fwdbv_pkg::t_status status;
        logic [4:0]         occupancy;
    } t_list_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 i_opcode = fwdbv_pkg::OP_INSERT;
    logic signed [fwdbv_pkg::VALUE_W-1:0] i_value = '0;
    logic                                 busy;
    logic                                 o_valid;
    logic [1:0]                           o_status;
    logic [4:0]                           o_occupancy;

    // predicted list contents, oldest first, and outcomes still to arrive
    logic signed [fwdbv_pkg::VALUE_W-1:0] list_model [$];
    t_list_result                         pending_results [$];
    int                                   mismatch_count = 0;
    int                                   result_count = 0;
    int                                   cycle_count = 0;
    int                                   sender_idle_pct = 0;

    fifo_with_delete_by_value_core #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_occupancy(o_occupancy)
    );

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fifo_with_delete_by_value_core: mismatch");
            $finish;
        end
    end

    // apply one operation to the predicted list and return its outcome
    function automatic t_list_result apply_to_model(
        input logic                                 op,
        input logic signed [fwdbv_pkg::VALUE_W-1:0] val
    );
        t_list_result outcome;
        int           hit;
        hit = -1;
        if (op == fwdbv_pkg::OP_INSERT) begin
            if (list_model.size() >= LIST_DEPTH) begin
                outcome.status = fwdbv_pkg::ST_DROPPED;
            end else begin
                list_model.push_back(val);
                outcome.status = fwdbv_pkg::ST_INSERTED;
            end
        end else begin
            // oldest matching entry goes, later ones close up
            for (int k = 0; k < list_model.size(); k++) begin
                if (hit < 0 && list_model[k] === val)
                    hit = k;
            end
            if (hit >= 0) begin
                list_model.delete(hit);
                outcome.status = fwdbv_pkg::ST_REMOVED;
            end else begin
                outcome.status = fwdbv_pkg::ST_NOT_FOUND;
            end
        end
        outcome.occupancy = 5'(list_model.size());
        return outcome;
    endfunction

    // send one transaction, with a random gap first; returns at the accepting edge
    task automatic send_op(
        input logic                                 op,
        input logic signed [fwdbv_pkg::VALUE_W-1:0] val
    );
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_to_model(op, val));
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            result_count++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %0d: unexpected, status %0d occupancy %0d",
                                        result_count, o_status, o_occupancy));
            end else begin
                want = pending_results.pop_front();
                if (o_valid !== 1'b1 || o_status !== want.status
                        || o_occupancy !== want.occupancy)
                    note_mismatch($sformatf(
                        "result %0d: expected %s occupancy %0d, got status %0d occupancy %0d",
                        result_count, want.status.name(), want.occupancy, o_status,
                        o_occupancy));
            end
        end
    end

    // remove from an empty list
    task automatic test_remove_from_empty();
        send_op(fwdbv_pkg::OP_REMOVE, 32'sh0000_0000);
    endtask

    // fill to capacity with extreme and duplicate values, then overflow
    task automatic test_fill_to_overflow();
        logic signed [fwdbv_pkg::VALUE_W-1:0] fill_vals [16];
        fill_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
                      32'sh0000_0001, 32'sh5555_5555, 32'shaaaa_aaaa, 32'shffff_ffff,
                      32'sh1234_5678, 32'sh7fff_fffe, 32'sh8000_0001, 32'sh0f0f_0f0f,
                      32'shf0f0_f0f0, 32'sh0000_0002, 32'shffff_fffe, 32'sh2468_ace0};
        for (int k = 0; k < LIST_DEPTH && k < 16; k++)
            send_op(fwdbv_pkg::OP_INSERT, fill_vals[k]);
        send_op(fwdbv_pkg::OP_INSERT, 32'sh1357_9bdf);
        // delete from the middle, later entries must keep their order
        send_op(fwdbv_pkg::OP_REMOVE, 32'sh5555_5555);
    endtask

    // duplicates go oldest first, then the value is gone
    task automatic test_duplicate_removal();
        repeat (3) send_op(fwdbv_pkg::OP_REMOVE, 32'shffff_ffff);
    endtask

    // mixed traffic from a small value pool so removes often hit
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        logic signed [fwdbv_pkg::VALUE_W-1:0] pool [8];
        int                                   insert_pct;
        int                                   pick;
        logic                                 op;
        logic signed [fwdbv_pkg::VALUE_W-1:0] val;
        sender_idle_pct = idle_pct;
        insert_pct = 50;
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7fff_ffff;
        pool[2] = 32'sh0000_0000;
        pool[3] = 32'shffff_ffff;
        for (int k = 4; k < 8; k++)
            pool[k] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            // swing between filling and emptying runs
            if (n % 50 == 0)
                insert_pct = 20 + 30 * $urandom_range(2);
            op = ($urandom_range(99) < insert_pct) ? fwdbv_pkg::OP_INSERT
                                                   : fwdbv_pkg::OP_REMOVE;
            pick = $urandom_range(99);
            if (pick < 15)
                val = $urandom;
            else if (pick < 40 && list_model.size() != 0)
                val = list_model[$urandom_range(list_model.size() - 1)];
            else
                val = pool[$urandom_range(7)];
            send_op(op, val);
        end
    endtask

    // sequence of tests
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_from_empty();
        test_fill_to_overflow();
        test_duplicate_removal();
        drain_results();

        test_random_traffic(640, 12);
        drain_results();
        test_random_traffic(640, 72);
        drain_results();
        test_random_traffic(650, 0);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("fifo_with_delete_by_value_core: match");
        else
            $display("fifo_with_delete_by_value_core: mismatch");
        $finish;
    end

endmodule
